// ===== hdl/avt_pkg.sv =====
package avt_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned ACC_W     = PROD_W + 3;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NUM_REGS  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_4 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PAIR_5 = CFG_IDX_W'(5);

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // load enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } avt_adv_t;

endpackage

// ===== hdl/avt_in_if.sv =====
interface avt_in_if
    import avt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] in_x;
    logic signed [WORD_W-1:0] in_y;
    logic signed [WORD_W-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

// ===== hdl/avt_out_if.sv =====
interface avt_out_if
    import avt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

// ===== hdl/avt_lane.sv =====
module avt_lane
    import avt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)(
    input  logic                     clk,
    input  avt_adv_t                 adv,
    input  logic signed [WORD_W-1:0] x,
    input  logic signed [WORD_W-1:0] y,
    input  logic signed [WORD_W-1:0] z,
    input  logic signed [WORD_W-1:0] cx,
    input  logic signed [WORD_W-1:0] cy,
    input  logic signed [WORD_W-1:0] cz,
    input  logic signed [WORD_W-1:0] ct,
    output logic signed [WORD_W-1:0] result
);

    logic signed [PROD_W-1:0] px_reg, px_next;
    logic signed [PROD_W-1:0] py_reg, py_next;
    logic signed [PROD_W-1:0] pz_reg, pz_next;
    logic signed [ACC_W-1:0]  tr_reg, tr_next;
    logic signed [ACC_W-1:0]  sum_a_reg, sum_a_next;
    logic signed [ACC_W-1:0]  sum_b_reg, sum_b_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [WORD_W-1:0] res_reg, res_next;

    always_comb
    begin
        px_next = x * cx;
        py_next = y * cy;
        pz_next = z * cz;
        tr_next = ACC_W'(ct) <<< FRAC_BITS;
    end

    always_comb
    begin
        sum_a_next = ACC_W'(px_reg) + ACC_W'(py_reg);
        sum_b_next = ACC_W'(pz_reg) + tr_reg;
    end

    assign acc_next = sum_a_reg + sum_b_reg;

    // floor shift, then clamp to the 32-bit range
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        if (&shifted[ACC_W-1:WORD_W-1] || ~|shifted[ACC_W-1:WORD_W-1])
        begin
            res_next = shifted[WORD_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            res_next = WORD_MIN;
        end
        else
        begin
            res_next = WORD_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            tr_reg <= tr_next;
        end
        if (adv.s2)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (adv.s3)
        begin
            acc_reg <= acc_next;
        end
        if (adv.s4)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== hdl/affine_vertex_transform.sv =====
// Channel   Dir   Payload                        Handshake
// pt_in     in    in_x, in_y, in_z  (Q16.16)     valid / ready
// pt_out    out   out_x, out_y, out_z (Q16.16)   valid / ready
// cfg       in    cfg_index, cfg_data (64 bit)   cfg_we, no back-pressure
//
// Four register stages: multiply, pairwise add, final add, shift and clamp.
// One point per clock unless pt_out stalls; beats pass every stage register in turn.
// The 32x32 multipliers of stage one set the clock; each lane has three.
// rst_n clears the stage valid bits and loads the identity matrix.
// A stall holds only the stages that are full; bubbles ahead of it still fill.
module affine_vertex_transform
    import avt_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    avt_in_if.sink               pt_in,
    avt_out_if.source            pt_out
);

    localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] coef_pair_reg  [NUM_REGS];
    logic [CFG_W-1:0] coef_pair_next [NUM_REGS];
    logic [3:0]       valid_reg, valid_next;
    avt_adv_t         adv;

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            coef_pair_next[i] = coef_pair_reg[i];
        end
        if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_PAIR_0: coef_pair_next[0] = cfg_data;
                REG_COEF_PAIR_1: coef_pair_next[1] = cfg_data;
                REG_COEF_PAIR_2: coef_pair_next[2] = cfg_data;
                REG_COEF_PAIR_3: coef_pair_next[3] = cfg_data;
                REG_COEF_PAIR_4: coef_pair_next[4] = cfg_data;
                REG_COEF_PAIR_5: coef_pair_next[5] = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_pair_reg[0] <= COEF_ONE;
            coef_pair_reg[1] <= '0;
            coef_pair_reg[2] <= COEF_ONE;
            coef_pair_reg[3] <= '0;
            coef_pair_reg[4] <= COEF_ONE;
            coef_pair_reg[5] <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_pair_reg[i] <= coef_pair_next[i];
            end
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        adv.s4 = !valid_reg[3] || pt_out.ready;
        adv.s3 = !valid_reg[2] || adv.s4;
        adv.s2 = !valid_reg[1] || adv.s3;
        adv.s1 = !valid_reg[0] || adv.s2;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv.s1)
        begin
            valid_next[0] = pt_in.valid;
        end
        if (adv.s2)
        begin
            valid_next[1] = valid_reg[0];
        end
        if (adv.s3)
        begin
            valid_next[2] = valid_reg[1];
        end
        if (adv.s4)
        begin
            valid_next[3] = valid_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pt_in.ready  = adv.s1;
    assign pt_out.valid = valid_reg[3];

    avt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk    (clk),
        .adv    (adv),
        .x      (pt_in.in_x),
        .y      (pt_in.in_y),
        .z      (pt_in.in_z),
        .cx     (coef_pair_reg[0][WORD_W-1:0]),
        .cy     (coef_pair_reg[1][CFG_W-1:WORD_W]),
        .cz     (coef_pair_reg[3][WORD_W-1:0]),
        .ct     (coef_pair_reg[4][CFG_W-1:WORD_W]),
        .result (pt_out.out_x)
    );

    avt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk    (clk),
        .adv    (adv),
        .x      (pt_in.in_x),
        .y      (pt_in.in_y),
        .z      (pt_in.in_z),
        .cx     (coef_pair_reg[0][CFG_W-1:WORD_W]),
        .cy     (coef_pair_reg[2][WORD_W-1:0]),
        .cz     (coef_pair_reg[3][CFG_W-1:WORD_W]),
        .ct     (coef_pair_reg[5][WORD_W-1:0]),
        .result (pt_out.out_y)
    );

    avt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk    (clk),
        .adv    (adv),
        .x      (pt_in.in_x),
        .y      (pt_in.in_y),
        .z      (pt_in.in_z),
        .cx     (coef_pair_reg[1][WORD_W-1:0]),
        .cy     (coef_pair_reg[2][CFG_W-1:WORD_W]),
        .cz     (coef_pair_reg[4][WORD_W-1:0]),
        .ct     (coef_pair_reg[5][CFG_W-1:WORD_W]),
        .result (pt_out.out_z)
    );

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pt_in.valid && pt_in.ready |=> valid_reg[0])
        else $error("accepted input beat did not reach stage one");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        pt_out.valid && !pt_out.ready && (&valid_reg) |-> !pt_in.ready)
        else $error("input taken while pipeline is full and stalled");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && !adv.s4 |=> valid_reg[2] && valid_reg[3])
        else $error("stalled beat lost in stage three");

endmodule

// ===== sim/tb_affine_vertex_transform.sv =====
`timescale 1ns / 100ps

module tb_affine_vertex_transform;
    import avt_pkg::*;

    localparam int FRAC        = 16;
    localparam int SUM_W       = 96;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 300;
    localparam int DIR_ROWS    = 26;

    localparam logic signed [WORD_W-1:0] Q_ONE = 32'sd1 <<< FRAC;

    // indexes past the last coefficient pair; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = CFG_IDX_W'(7);

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
    } vertex_t;

    typedef enum logic [1:0] {
        ROW_POINT,      // point with its result typed in
        ROW_POINT_CHK,  // point checked against the transform
        ROW_REG,        // write one register
        ROW_FILL        // write the same value to every coefficient pair
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        vertex_t              pt;
        vertex_t              want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    avt_in_if  pt_in ();
    avt_out_if pt_out ();

    affine_vertex_transform #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pt_in     (pt_in),
        .pt_out    (pt_out)
    );

    logic [CFG_W-1:0] coef_regs [NUM_REGS];
    vertex_t          pending_vertices [$];
    int               error_count  = 0;
    int               stall_cycles = 0;
    int               src_idle_pct = 17;
    int               snk_idle_pct = 61;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{32'sd0, 32'sd0, 32'sd0}, '{32'sd0, 32'sd0, 32'sd0}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MAX, WORD_MIN, -32'sd1}, '{WORD_MAX, WORD_MIN, -32'sd1}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MIN, WORD_MAX, 32'sd1}, '{WORD_MIN, WORD_MAX, 32'sd1}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{32'sh1234_5678, 32'shDEAD_BEEF, 32'sh0001_0000},
          '{32'sh1234_5678, 32'shDEAD_BEEF, 32'sh0001_0000}},
        '{ROW_REG, REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
        '{ROW_REG, REG_SPARE_7, 64'h8000_0000_7FFF_FFFF, '0, '0},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{32'sd5, -32'sd6, 32'sd7}, '{32'sd5, -32'sd6, 32'sd7}},
        '{ROW_FILL, REG_COEF_PAIR_0, {WORD_MAX, WORD_MAX}, '0, '0},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MAX, WORD_MAX, WORD_MAX}, '{WORD_MAX, WORD_MAX, WORD_MAX}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MIN, WORD_MIN, WORD_MIN}, '{WORD_MIN, WORD_MIN, WORD_MIN}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{32'sd0, 32'sd0, 32'sd0}, '{WORD_MAX, WORD_MAX, WORD_MAX}},
        '{ROW_FILL, REG_COEF_PAIR_0, {WORD_MIN, WORD_MIN}, '0, '0},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MIN, WORD_MIN, WORD_MIN}, '{WORD_MAX, WORD_MAX, WORD_MAX}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MAX, WORD_MAX, WORD_MAX}, '{WORD_MIN, WORD_MIN, WORD_MIN}},
        '{ROW_POINT, REG_COEF_PAIR_0, 64'd0,
          '{32'sd0, 32'sd0, 32'sd0}, '{WORD_MIN, WORD_MIN, WORD_MIN}},
        '{ROW_REG, REG_COEF_PAIR_0, 64'hFFFF_8000_0000_8000, '0, '0},
        '{ROW_REG, REG_COEF_PAIR_1, 64'h0002_0000_FFFF_FFFF, '0, '0},
        '{ROW_REG, REG_COEF_PAIR_2, 64'h0001_0000_FFFF_0000, '0, '0},
        '{ROW_REG, REG_COEF_PAIR_3, 64'h0000_0001_FFFF_FFFF, '0, '0},
        '{ROW_REG, REG_COEF_PAIR_4, 64'hFFFF_FFFF_0003_0000, '0, '0},
        '{ROW_REG, REG_COEF_PAIR_5, 64'h7FFF_FFFF_8000_0000, '0, '0},
        // half-LSB products: the shift must floor toward minus infinity
        '{ROW_POINT_CHK, REG_COEF_PAIR_0, 64'd0, '{-32'sd1, 32'sd0, 32'sd0}, '0},
        '{ROW_POINT_CHK, REG_COEF_PAIR_0, 64'd0, '{32'sd1, 32'sd1, 32'sd1}, '0},
        '{ROW_POINT_CHK, REG_COEF_PAIR_0, 64'd0,
          '{32'sh0001_0000, 32'shFFFF_0000, WORD_MAX}, '0},
        '{ROW_POINT_CHK, REG_COEF_PAIR_0, 64'd0,
          '{WORD_MIN, 32'sh0000_8000, -32'sd3}, '0},
        '{ROW_POINT_CHK, REG_COEF_PAIR_0, 64'd0,
          '{32'sd3, WORD_MAX, WORD_MIN}, '0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // matrix entry k of the row-major 4x4; the w column has no register
    function automatic logic signed [WORD_W-1:0] mcoef(int unsigned k);
        case (k)
            0:  return coef_regs[REG_COEF_PAIR_0][31:0];
            1:  return coef_regs[REG_COEF_PAIR_0][63:32];
            2:  return coef_regs[REG_COEF_PAIR_1][31:0];
            4:  return coef_regs[REG_COEF_PAIR_1][63:32];
            5:  return coef_regs[REG_COEF_PAIR_2][31:0];
            6:  return coef_regs[REG_COEF_PAIR_2][63:32];
            8:  return coef_regs[REG_COEF_PAIR_3][31:0];
            9:  return coef_regs[REG_COEF_PAIR_3][63:32];
            10: return coef_regs[REG_COEF_PAIR_4][31:0];
            12: return coef_regs[REG_COEF_PAIR_4][63:32];
            13: return coef_regs[REG_COEF_PAIR_5][31:0];
            14: return coef_regs[REG_COEF_PAIR_5][63:32];
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [WORD_W-1:0] lane_value(int unsigned j, vertex_t p);
        logic signed [SUM_W-1:0] cx, cy, cz, ct, px, py, pz, acc;
        cx  = mcoef(j);
        cy  = mcoef(4 + j);
        cz  = mcoef(8 + j);
        ct  = mcoef(12 + j);
        px  = p.x;
        py  = p.y;
        pz  = p.z;
        acc = cx * px + cy * py + cz * pz + (ct <<< FRAC);
        acc = acc >>> FRAC;
        if (acc > WORD_MAX)
            return WORD_MAX;
        if (acc < WORD_MIN)
            return WORD_MIN;
        return acc[WORD_W-1:0];
    endfunction

    function automatic vertex_t transform_point(vertex_t p);
        vertex_t r;
        r.x = lane_value(0, p);
        r.y = lane_value(1, p);
        r.z = lane_value(2, p);
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return $urandom;
        if (pick < 70)
            return WORD_W'($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000;
        if (pick < 85)
        begin
            case ($urandom_range(4))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return WORD_W'($urandom_range(511)) - 32'sd256;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_coef();
        int unsigned pick;
        pick = $urandom_range(99);
        // mostly within +/-4.0, so that outputs stay in range often enough
        if (pick < 45)
            return WORD_W'($urandom_range(32'h0007_FFFF)) - 32'sh0004_0000;
        if (pick < 65)
            return $urandom;
        if (pick < 80)
            return ($urandom_range(1) != 0) ? WORD_MAX : WORD_MIN;
        if (pick < 90)
        begin
            case ($urandom_range(2))
                0:       return Q_ONE;
                1:       return -Q_ONE;
                default: return 32'sd0;
            endcase
        end
        return WORD_W'($urandom_range(511)) - 32'sd256;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx < NUM_REGS)
            coef_regs[idx] = data;
    endtask

    // hold off the input and wait until every result has come back
    task automatic drain();
        pt_in.valid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_point(input vertex_t p, input bit typed, input vertex_t want);
        cfg_we <= 1'b0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pt_in.valid <= 1'b0;
            @(posedge clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.in_x  <= p.x;
        pt_in.in_y  <= p.y;
        pt_in.in_z  <= p.z;
        do
            @(posedge clk);
        while (!pt_in.ready);
        pending_vertices.push_back(typed ? want : transform_point(p));
    endtask

    initial
    begin : out_side
        vertex_t want;
        pt_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pt_out.valid && pt_out.ready)
            begin
                if (pending_vertices.size() == 0)
                begin
                    $error("output beat with nothing pending: x=%0d y=%0d z=%0d",
                           pt_out.out_x, pt_out.out_y, pt_out.out_z);
                    error_count++;
                end
                else
                begin
                    want = pending_vertices.pop_front();
                    if (pt_out.out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, pt_out.out_x);
                        error_count++;
                    end
                    if (pt_out.out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, pt_out.out_y);
                        error_count++;
                    end
                    if (pt_out.out_z !== want.z)
                    begin
                        $error("out_z: expected %0d, got %0d", want.z, pt_out.out_z);
                        error_count++;
                    end
                end
            end
            pt_out.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((pt_in.valid && pt_in.ready) || (pt_out.valid && pt_out.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_affine_vertex_transform: done, errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_COEF_PAIR_0;
        cfg_data    = '0;
        pt_in.valid = 1'b0;
        pt_in.in_x  = '0;
        pt_in.in_y  = '0;
        pt_in.in_z  = '0;
        // identity after reset: 1.0 on the diagonal, in the low half of the even pairs
        for (int k = 0; k < NUM_REGS; k++)
            coef_regs[k] = (k % 2 == 0) ? {32'h0, Q_ONE} : '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_POINT:     send_point(row.pt, 1'b1, row.want);
                ROW_POINT_CHK: send_point(row.pt, 1'b0, '0);
                ROW_REG:
                begin
                    drain();
                    write_reg(row.idx, row.data);
                end
                default:
                begin
                    drain();
                    for (int k = 0; k < NUM_REGS; k++)
                        write_reg(REG_COEF_PAIR_0 + CFG_IDX_W'(k), row.data);
                end
            endcase
        end

        // receiver idles more, then sender idles more, then neither idles
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ((ph * 3) / PHASES)
                0:
                begin
                    src_idle_pct = 17;
                    snk_idle_pct = 61;
                end
                1:
                begin
                    src_idle_pct = 61;
                    snk_idle_pct = 17;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            drain();
            for (int k = 0; k < NUM_REGS; k++)
                write_reg(REG_COEF_PAIR_0 + CFG_IDX_W'(k), {rand_coef(), rand_coef()});
            if ($urandom_range(1) != 0)
                write_reg(($urandom_range(1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
                          {$urandom, $urandom});
            repeat (PHASE_ITEMS)
                send_point('{rand_word(), rand_word(), rand_word()}, 1'b0, '0);
        end

        drain();
        // catch any stray beat after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_affine_vertex_transform: done, clean");
        else
            $display("tb_affine_vertex_transform: done, errors");
        $finish;
    end

endmodule

// ===== affine_vertex_transform.f =====
hdl/avt_pkg.sv
hdl/avt_in_if.sv
hdl/avt_out_if.sv
hdl/avt_lane.sv
hdl/affine_vertex_transform.sv
sim/tb_affine_vertex_transform.sv
